FILE: rtl/beam_circle_hit_test_core_macros.svh
// Assertion macros for the beam hit test core checker.
`ifndef BEAM_CIRCLE_HIT_TEST_CORE_MACROS_SVH
`define BEAM_CIRCLE_HIT_TEST_CORE_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define BCHIT_ASSERT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define BCHIT_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/bchit_pkg.sv
// Package: types, constants and sine table for the beam hit test core.
`default_nettype none
package bchit_pkg;

	localparam int PT_W     = 17;
	localparam int RAD_W    = 12;
	localparam int ANG_W    = 12;
	localparam int LEN_W    = 16;
	localparam int THK_W    = 12;
	localparam int TRIG_W   = 16;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DAT_W = 17;

	localparam int SINE_TABLE_ENTRIES = 1024;
	localparam int SINE_IDX_W = $clog2(SINE_TABLE_ENTRIES);
	localparam int SINE_MUL_W = 10 + $clog2(SINE_TABLE_ENTRIES + 1);
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam logic [63:0] ROM_X_DIV = 64'(2 * SINE_TABLE_ENTRIES);
	localparam logic [15:0] Q15_ONE = 16'd32767;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_BEAM_LIVE      = 3'd0,
		REG_ORIGIN_X       = 3'd1,
		REG_ORIGIN_Y       = 3'd2,
		REG_BEAM_ANGLE     = 3'd3,
		REG_BEAM_LENGTH    = 3'd4,
		REG_BEAM_THICKNESS = 3'd5
	} reg_idx_t;

	localparam logic [THK_W-1:0] THICKNESS_RST = 12'd288;

	typedef struct packed {
		logic                     live;
		logic signed [PT_W-1:0]   origin_x;
		logic signed [PT_W-1:0]   origin_y;
		logic [LEN_W-1:0]         length;
		logic [THK_W-1:0]         thickness;
		logic signed [TRIG_W-1:0] dir_c;
		logic signed [TRIG_W-1:0] dir_s;
	} beam_cfg_t;

	typedef logic [14:0] sine_rom_t [SINE_TABLE_ENTRIES];

	// Taylor step divisors (2k)(2k+1).
	function automatic logic [63:0] taylor_div(input logic [63:0] term, input int k);
		case (k)
			1:       return term / 64'd6;
			2:       return term / 64'd20;
			3:       return term / 64'd42;
			4:       return term / 64'd72;
			5:       return term / 64'd110;
			default: return term / 64'd156;
		endcase
	endfunction

	// Quarter-wave Q1.15 table, built at elaboration.
	function automatic sine_rom_t build_sine_rom();
		sine_rom_t          rom;
		logic [63:0]        x;
		logic [63:0]        term;
		logic signed [63:0] acc;
		logic [63:0]        v;
		for (int i = 0; i < SINE_TABLE_ENTRIES; i++) begin
			x = (PI_Q30 * 64'(i)) / ROM_X_DIV;
			term = x;
			acc = signed'(x);
			for (int k = 1; k <= 6; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = taylor_div(term, k);
				if ((k & 1) == 1) begin
					acc = acc - signed'(term);
				end else begin
					acc = acc + signed'(term);
				end
			end
			if (acc < 0) begin
				acc = 64'sd0;
			end
			v = (unsigned'(acc) + 64'd16384) >> 15;
			if (v > 64'd32767) begin
				v = 64'd32767;
			end
			rom[i] = v[14:0];
		end
		return rom;
	endfunction

	localparam sine_rom_t SINE_ROM = build_sine_rom();

	// p in 0..1024, 1/4096 turn.
	function automatic logic [TRIG_W-1:0] quarter_sine(input logic [10:0] p);
		logic [SINE_MUL_W-1:0] prod;
		logic [SINE_IDX_W-1:0] idx;
		prod = SINE_MUL_W'(p[9:0]) * SINE_MUL_W'(SINE_TABLE_ENTRIES);
		idx = SINE_IDX_W'(prod >> 10);
		if (p[10]) begin
			return Q15_ONE;
		end
		return {1'b0, SINE_ROM[idx]};
	endfunction

	function automatic logic signed [TRIG_W-1:0] sine_of(input logic [ANG_W-1:0] a);
		logic [1:0]        q;
		logic [10:0]       arg;
		logic [TRIG_W-1:0] v;
		q = a[11:10];
		arg = q[0] ? (11'd1024 - {1'b0, a[9:0]}) : {1'b0, a[9:0]};
		v = quarter_sine(arg);
		return q[1] ? -signed'(v) : signed'(v);
	endfunction

endpackage
`default_nettype wire

FILE: rtl/bchit_cfg.sv
// Beam configuration registers and registered direction vector.
`default_nettype none
module bchit_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [bchit_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bchit_pkg::CFG_DAT_W-1:0]   cfg_wdata,
	output bchit_pkg::beam_cfg_t              beam
);
	import bchit_pkg::*;

	logic                     live_q;
	logic signed [PT_W-1:0]   origin_x_q;
	logic signed [PT_W-1:0]   origin_y_q;
	logic [ANG_W-1:0]         angle_q;
	logic [LEN_W-1:0]         length_q;
	logic [THK_W-1:0]         thickness_q;
	logic signed [TRIG_W-1:0] dir_c_q;
	logic signed [TRIG_W-1:0] dir_s_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q      <= 1'b0;
			origin_x_q  <= '0;
			origin_y_q  <= '0;
			angle_q     <= '0;
			length_q    <= '0;
			thickness_q <= THICKNESS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BEAM_LIVE:      live_q      <= cfg_wdata[0];
				REG_ORIGIN_X:       origin_x_q  <= signed'(cfg_wdata[PT_W-1:0]);
				REG_ORIGIN_Y:       origin_y_q  <= signed'(cfg_wdata[PT_W-1:0]);
				REG_BEAM_ANGLE:     angle_q     <= cfg_wdata[ANG_W-1:0];
				REG_BEAM_LENGTH:    length_q    <= cfg_wdata[LEN_W-1:0];
				REG_BEAM_THICKNESS: thickness_q <= cfg_wdata[THK_W-1:0];
				default: ;
			endcase
		end
	end

	// cos(a) = sin(a + quarter turn); refreshed every cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_c_q <= signed'(Q15_ONE);
			dir_s_q <= '0;
		end else begin
			dir_c_q <= sine_of(angle_q + 12'd1024);
			dir_s_q <= sine_of(angle_q);
		end
	end

	always_comb begin
		beam.live      = live_q;
		beam.origin_x  = origin_x_q;
		beam.origin_y  = origin_y_q;
		beam.length    = length_q;
		beam.thickness = thickness_q;
		beam.dir_c     = dir_c_q;
		beam.dir_s     = dir_s_q;
	end

endmodule
`default_nettype wire

FILE: rtl/bchit_pipe.sv
// Six-stage hit test datapath with valid/ready flow control.
`default_nettype none
module bchit_pipe (
	input  logic                                clk,
	input  logic                                arst_n,
	input  bchit_pkg::beam_cfg_t                beam,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [bchit_pkg::PT_W-1:0]   point_x,
	input  logic signed [bchit_pkg::PT_W-1:0]   point_y,
	input  logic [bchit_pkg::RAD_W-1:0]         circle_radius,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit
);
	import bchit_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5, v_s6;
	logic rdy1, rdy2, rdy3, rdy4, rdy5, rdy6;

	assign rdy6 = !v_s6 || out_ready;
	assign rdy5 = !v_s5 || rdy6;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;
	assign in_ready = rdy1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
		end else begin
			if (rdy1) v_s1 <= in_valid;
			if (rdy2) v_s2 <= v_s1;
			if (rdy3) v_s3 <= v_s2;
			if (rdy4) v_s4 <= v_s3;
			if (rdy5) v_s5 <= v_s4;
			if (rdy6) v_s6 <= v_s5;
		end
	end

	// s1: offsets from origin, doubled combined radius
	logic               live_s1;
	logic signed [17:0] wx_s1, wy_s1;
	logic [13:0]        k_s1;

	always_ff @(posedge clk) begin
		if (rdy1 && in_valid) begin
			live_s1 <= beam.live;
			wx_s1   <= 18'(point_x) - 18'(beam.origin_x);
			wy_s1   <= 18'(point_y) - 18'(beam.origin_y);
			k_s1    <= 14'(beam.thickness) + 14'({circle_radius, 1'b0});
		end
	end

	// s2: products
	logic               live_s2;
	logic signed [17:0] wx_s2, wy_s2;
	logic signed [33:0] wxc_s2, wys_s2, wxs_s2, wyc_s2;
	logic [33:0]        wxx_s2, wyy_s2;
	logic signed [32:0] lc_s2, ls_s2;
	logic [29:0]        cc_s2, ss_s2;
	logic [27:0]        k2_s2;
	logic signed [35:0] wxx_full, wyy_full;
	logic signed [31:0] cc_full, ss_full;
	logic signed [32:0] len_sx;

	assign wxx_full = 36'(wx_s1) * 36'(wx_s1);
	assign wyy_full = 36'(wy_s1) * 36'(wy_s1);
	assign cc_full  = 32'(beam.dir_c) * 32'(beam.dir_c);
	assign ss_full  = 32'(beam.dir_s) * 32'(beam.dir_s);
	assign len_sx   = signed'(33'(beam.length));

	always_ff @(posedge clk) begin
		if (rdy2 && v_s1) begin
			live_s2 <= live_s1;
			wx_s2   <= wx_s1;
			wy_s2   <= wy_s1;
			wxc_s2  <= 34'(wx_s1) * 34'(beam.dir_c);
			wys_s2  <= 34'(wy_s1) * 34'(beam.dir_s);
			wxs_s2  <= 34'(wx_s1) * 34'(beam.dir_s);
			wyc_s2  <= 34'(wy_s1) * 34'(beam.dir_c);
			wxx_s2  <= wxx_full[33:0];
			wyy_s2  <= wyy_full[33:0];
			lc_s2   <= len_sx * 33'(beam.dir_c);
			ls_s2   <= len_sx * 33'(beam.dir_s);
			cc_s2   <= cc_full[29:0];
			ss_s2   <= ss_full[29:0];
			k2_s2   <= 28'(k_s1) * 28'(k_s1);
		end
	end

	// s3: sums
	logic               live_s3;
	logic signed [34:0] dot_s3, cross_s3;
	logic [34:0]        d2_s3;
	logic signed [33:0] vx_s3, vy_s3;
	logic [30:0]        m_s3;
	logic [27:0]        k2_s3;

	always_ff @(posedge clk) begin
		if (rdy3 && v_s2) begin
			live_s3  <= live_s2;
			dot_s3   <= 35'(wxc_s2) + 35'(wys_s2);
			cross_s3 <= 35'(wxs_s2) - 35'(wyc_s2);
			d2_s3    <= 35'(wxx_s2) + 35'(wyy_s2);
			vx_s3    <= (34'(wx_s2) <<< 15) - 34'(lc_s2);
			vy_s3    <= (34'(wy_s2) <<< 15) - 34'(ls_s2);
			m_s3     <= 31'(cc_s2) + 31'(ss_s2);
			k2_s3    <= k2_s2;
		end
	end

	// s4: magnitudes, range checks, length*M, origin test
	logic        live_s4, dot_pos_s4, origin_hit_s4, end_ok_s4, side_ok_s4;
	logic [33:0] dot_s4;
	logic [46:0] lenm_s4;
	logic [29:0] ax_s4, ay_s4;
	logic [30:0] ac_s4;
	logic [30:0] m_s4;
	logic [27:0] k2_s4;
	logic [33:0] vx_abs, vy_abs;
	logic [34:0] cross_abs;

	assign vx_abs    = vx_s3[33] ? unsigned'(-vx_s3) : unsigned'(vx_s3);
	assign vy_abs    = vy_s3[33] ? unsigned'(-vy_s3) : unsigned'(vy_s3);
	assign cross_abs = cross_s3[34] ? unsigned'(-cross_s3) : unsigned'(cross_s3);

	always_ff @(posedge clk) begin
		if (rdy4 && v_s3) begin
			live_s4       <= live_s3;
			dot_pos_s4    <= !dot_s3[34] && (dot_s3 != 35'sd0);
			dot_s4        <= unsigned'(dot_s3[33:0]);
			lenm_s4       <= 47'(beam.length) * 47'(m_s3);
			origin_hit_s4 <= {d2_s3, 2'b00} < 37'(k2_s3);
			end_ok_s4     <= (vx_abs[33:30] == 4'd0) && (vy_abs[33:30] == 4'd0);
			side_ok_s4    <= (cross_abs[34:31] == 4'd0);
			ax_s4         <= vx_abs[29:0];
			ay_s4         <= vy_abs[29:0];
			ac_s4         <= cross_abs[30:0];
			m_s4          <= m_s3;
			k2_s4         <= k2_s3;
		end
	end

	// s5: squares and thresholds
	logic        live_s5, dot_pos_s5, origin_hit_s5, end_ok_s5, side_ok_s5, past_end_s5;
	logic [59:0] ax2_s5, ay2_s5;
	logic [61:0] ac2_s5;
	logic [58:0] k2m_s5;
	logic [27:0] k2_s5;

	always_ff @(posedge clk) begin
		if (rdy5 && v_s4) begin
			live_s5       <= live_s4;
			dot_pos_s5    <= dot_pos_s4;
			origin_hit_s5 <= origin_hit_s4;
			end_ok_s5     <= end_ok_s4;
			side_ok_s5    <= side_ok_s4;
			past_end_s5   <= {dot_s4, 15'd0} >= 49'(lenm_s4);
			ax2_s5        <= 60'(ax_s4) * 60'(ax_s4);
			ay2_s5        <= 60'(ay_s4) * 60'(ay_s4);
			ac2_s5        <= 62'(ac_s4) * 62'(ac_s4);
			k2m_s5        <= 59'(k2_s4) * 59'(m_s4);
			k2_s5         <= k2_s4;
		end
	end

	// s6: final compares and case select, output register
	logic        hit_s6;
	logic [60:0] end_sum;
	logic        end_hit, side_hit, hit_sel;

	assign end_sum  = 61'(ax2_s5) + 61'(ay2_s5);
	assign end_hit  = end_ok_s5 && ({end_sum, 2'b00} < 63'({k2_s5, 30'd0}));
	assign side_hit = side_ok_s5 && ({ac2_s5, 2'b00} < 64'(k2m_s5));

	always_comb begin
		if (!live_s5) begin
			hit_sel = 1'b0;
		end else if (!dot_pos_s5) begin
			hit_sel = origin_hit_s5;
		end else if (past_end_s5) begin
			hit_sel = end_hit;
		end else begin
			hit_sel = side_hit;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy6 && v_s5) begin
			hit_s6 <= hit_sel;
		end
	end

	assign out_valid = v_s6;
	assign hit       = hit_s6;

endmodule
`default_nettype wire

FILE: rtl/beam_circle_hit_test_core.sv
// Top level of the beam/circle hit test core.
//
//   channel   dir  handshake              word
//   in        in   in_valid / in_ready    point_x, point_y, circle_radius
//   out       out  out_valid / out_ready  hit
//   cfg       in   cfg_we (no wait)       cfg_index, cfg_wdata
//
// One word per cycle while out_ready stays high, through the six-stage
// multiply/add pipe. Direction vector is registered in the cycle after an
// angle write. arst_n clears all valids and config (thickness to 288).
// A stalled out_ready holds the result; earlier stages keep filling bubbles.
`default_nettype none
module beam_circle_hit_test_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic signed [bchit_pkg::PT_W-1:0]   point_x,
	input  logic signed [bchit_pkg::PT_W-1:0]   point_y,
	input  logic [bchit_pkg::RAD_W-1:0]         circle_radius,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	input  logic                                cfg_we,
	input  logic [bchit_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bchit_pkg::CFG_DAT_W-1:0]     cfg_wdata
);
	import bchit_pkg::*;

	beam_cfg_t beam;

	bchit_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.beam      (beam)
	);

	bchit_pipe u_pipe (
		.clk           (clk),
		.arst_n        (arst_n),
		.beam          (beam),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.circle_radius (circle_radius),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit)
	);

endmodule
`default_nettype wire

FILE: rtl/bchit_checker.sv
// Port-level assertion checker for the beam hit test core, with its bind.
`default_nettype none
`include "beam_circle_hit_test_core_macros.svh"
module bchit_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic                              hit,
	input  logic                              cfg_we,
	input  logic [bchit_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [bchit_pkg::CFG_DAT_W-1:0]   cfg_wdata
);
	import bchit_pkg::*;

	logic live_q;

	// shadow of the live flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			live_q <= 1'b0;
		end else if (cfg_we && (cfg_index == REG_BEAM_LIVE)) begin
			live_q <= cfg_wdata[0];
		end
	end

	`BCHIT_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(hit), "out word changed while stalled")
	`BCHIT_ASSERT(a_ready_flow, out_ready, in_ready, "input stalled while output drains")
	`BCHIT_ASSERT(a_dead_beam, out_valid && !live_q, !hit, "hit reported with beam not live")
	`BCHIT_ASSERT_NXT(a_latency, in_valid && in_ready && out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready ##1 out_ready, out_valid, "result missing six cycles after accept")

endmodule

bind beam_circle_hit_test_core bchit_checker u_bchit_checker (.*);
`default_nettype wire

FILE: tb/beam_circle_hit_test_core_test.sv
`timescale 1ns / 1ps
// Testbench for the beam/circle hit test core: scoreboard against an independent hit predictor.
module beam_circle_hit_test_core_test;
	import bchit_pkg::*;

	localparam int WAVE_N = SINE_TABLE_ENTRIES;
	localparam longint unsigned PI_Q30_VAL = 64'd3373259426;
	localparam int PIPE_LATENCY = 6;
	localparam int QUIET_LIMIT = 4000;
	localparam int LONG_HOLD = 300;
	localparam int RANDOM_PHASES = 12;
	localparam int WORDS_PER_PHASE = 90;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [CFG_IDX_W-1:0] IDX_SPARE_HI = 3'd7;
	localparam logic [ANG_W-1:0] KEY_ANGLES [6] = '{12'd0, 12'd1023, 12'd1024, 12'd2048,
		12'd3072, 12'd4095};

	typedef struct packed {
		logic signed [PT_W-1:0] x;
		logic signed [PT_W-1:0] y;
		logic [RAD_W-1:0]       r;
	} circle_t;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   in_valid = 1'b0;
	logic                   in_ready;
	logic signed [PT_W-1:0] point_x = '0;
	logic signed [PT_W-1:0] point_y = '0;
	logic [RAD_W-1:0]       circle_radius = '0;
	logic                   out_valid;
	logic                   out_ready = 1'b0;
	logic                   hit;
	logic                   cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0]   cfg_index = '0;
	logic [CFG_DAT_W-1:0]   cfg_wdata = '0;

	// beam register copy
	logic                   beam_on = 1'b0;
	logic signed [PT_W-1:0] org_x = '0;
	logic signed [PT_W-1:0] org_y = '0;
	logic [ANG_W-1:0]       angle = '0;
	logic [LEN_W-1:0]       len = '0;
	logic [THK_W-1:0]       thick = THICKNESS_RST;

	longint unsigned wave_q15 [WAVE_N];
	circle_t         circles_to_send [$];
	logic            expected_hits [$];
	circle_t         cur_circle;
	logic            want;
	int              tx_idle_pct = 20;
	int              rx_idle_pct = 82;
	int              rx_hold_left = 0;
	int              bad_words = 0;
	int              quiet_cycles = 0;

	beam_circle_hit_test_core dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.point_x       (point_x),
		.point_y       (point_y),
		.circle_radius (circle_radius),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.hit           (hit),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	always #2 clk = ~clk;

	// Quarter-wave Q1.15 sine: Taylor series to x^13 in Q30, rounded to Q15.
	function automatic void build_wave();
		longint unsigned x;
		longint unsigned term;
		longint          acc;
		longint unsigned v;
		for (int i = 0; i < WAVE_N; i++) begin
			x = (PI_Q30_VAL * i) / (2 * WAVE_N);
			term = x;
			acc = longint'(x);
			for (int k = 1; k <= 6; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / (2 * k * (2 * k + 1));
				if (k % 2 == 1) begin
					acc = acc - longint'(term);
				end else begin
					acc = acc + longint'(term);
				end
			end
			if (acc < 0) begin
				acc = 0;
			end
			v = ($unsigned(acc) + 64'd16384) >> 15;
			wave_q15[i] = (v > 64'd32767) ? 64'd32767 : v;
		end
	endfunction

	function automatic longint quarter_q15(input int unsigned p);
		if (p >= 1024) begin
			return 32767;
		end
		return longint'(wave_q15[((p * WAVE_N) >> 10) % WAVE_N]);
	endfunction

	function automatic longint sin_q15(input logic [ANG_W-1:0] a);
		int unsigned p;
		longint      v;
		p = a[9:0];
		v = a[10] ? quarter_q15(1024 - p) : quarter_q15(p);
		return a[11] ? -v : v;
	endfunction

	function automatic logic beam_hit(input circle_t cc);
		longint          wx, wy, sn, cs, dot, vx, vy, cr, k;
		longint unsigned k2, m, ax, ay, ac;
		if (!beam_on) begin
			return 1'b0;
		end
		wx = longint'(cc.x) - longint'(org_x);
		wy = longint'(cc.y) - longint'(org_y);
		k = longint'(thick) + 2 * longint'(cc.r);
		k2 = k * k;
		sn = sin_q15(angle);
		cs = sin_q15(ANG_W'(angle + 12'd1024));
		m = cs * cs + sn * sn;
		dot = wx * cs + wy * sn;
		if (dot <= 0) begin
			return (4 * (wx * wx + wy * wy)) < k2;
		end
		if (dot * 32768 >= longint'(len) * m) begin
			vx = wx * 32768 - longint'(len) * cs;
			vy = wy * 32768 - longint'(len) * sn;
			ax = (vx < 0) ? -vx : vx;
			ay = (vy < 0) ? -vy : vy;
			if (ax >= (64'd1 << 30) || ay >= (64'd1 << 30)) begin
				return 1'b0;
			end
			return (4 * (ax * ax + ay * ay)) < (k2 * (64'd1 << 30));
		end
		cr = wx * sn - wy * cs;
		ac = (cr < 0) ? -cr : cr;
		if (ac >= (64'd1 << 31)) begin
			return 1'b0;
		end
		return (4 * ac * ac) < (k2 * m);
	endfunction

	task automatic flag_word(input string what, input logic exp_hit, input logic got_hit);
		bad_words++;
		if (bad_words <= 10) begin
			$display("%0t: %s: expected hit %b, got %b", $realtime, what, exp_hit, got_hit);
		end
	endtask

	// driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && in_ready) begin
				expected_hits.push_back(beam_hit(cur_circle));
			end
			if (!in_valid || in_ready) begin
				if (circles_to_send.size() > 0 && $urandom_range(99) >= tx_idle_pct) begin
					cur_circle = circles_to_send.pop_front();
					point_x <= cur_circle.x;
					point_y <= cur_circle.y;
					circle_radius <= cur_circle.r;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (expected_hits.size() == 0) begin
					flag_word("word with nothing expected", 1'bx, hit);
				end else begin
					want = expected_hits.pop_front();
					if (hit !== want) begin
						flag_word("hit mismatch", want, hit);
					end
				end
			end
			if (rx_hold_left > 0) begin
				rx_hold_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) || cfg_we) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("%0t: timeout, no handshake for %0d cycles", $realtime, QUIET_LIMIT);
				$display("*** FAILED ***");
				$finish;
			end
		end
	end

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DAT_W-1:0] data);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= data;
		case (idx)
			REG_BEAM_LIVE:      beam_on = data[0];
			REG_ORIGIN_X:       org_x = data[PT_W-1:0];
			REG_ORIGIN_Y:       org_y = data[PT_W-1:0];
			REG_BEAM_ANGLE:     angle = data[ANG_W-1:0];
			REG_BEAM_LENGTH:    len = data[LEN_W-1:0];
			REG_BEAM_THICKNESS: thick = data[THK_W-1:0];
			default: ;
		endcase
	endtask

	// drop the write strobe and let the direction vector settle
	task automatic settle();
		@(posedge clk);
		cfg_we <= 1'b0;
		repeat (PIPE_LATENCY + 2) @(posedge clk);
	endtask

	task automatic set_beam(input logic live, input logic [PT_W-1:0] ox, input logic [PT_W-1:0] oy,
		input logic [ANG_W-1:0] ang, input logic [LEN_W-1:0] ln, input logic [THK_W-1:0] th);
		write_reg(REG_BEAM_LIVE, {16'($urandom()), live});
		write_reg(REG_ORIGIN_X, ox);
		write_reg(REG_ORIGIN_Y, oy);
		write_reg(REG_BEAM_ANGLE, {5'($urandom()), ang});
		write_reg(REG_BEAM_LENGTH, {1'($urandom()), ln});
		write_reg(REG_BEAM_THICKNESS, {5'($urandom()), th});
		settle();
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (circles_to_send.size() != 0 || in_valid || expected_hits.size() != 0);
		repeat (PIPE_LATENCY + 2) @(negedge clk);
	endtask

	task automatic offer_circle(input logic [PT_W-1:0] x, input logic [PT_W-1:0] y,
		input logic [RAD_W-1:0] r);
		circles_to_send.push_back('{x: x, y: y, r: r});
	endtask

	task automatic load_random_beam();
		logic             live;
		logic [PT_W-1:0]  ox, oy;
		logic [ANG_W-1:0] ang;
		logic [LEN_W-1:0] ln;
		logic [THK_W-1:0] th;
		int               pick;
		live = ($urandom_range(99) < 85);
		pick = $urandom_range(3);
		if (pick == 0) begin
			ox = $urandom_range(1) ? 17'h10000 : 17'h0FFFF;
			oy = $urandom_range(1) ? 17'h10000 : 17'h0FFFF;
		end else if (pick == 1) begin
			ox = 17'($urandom());
			oy = 17'($urandom());
		end else begin
			ox = 17'($urandom_range(8191)) - 17'd4096;
			oy = 17'($urandom_range(8191)) - 17'd4096;
		end
		ang = ($urandom_range(3) == 0) ? KEY_ANGLES[$urandom_range(5)] : 12'($urandom());
		case ($urandom_range(5))
			0:       ln = 16'd0;
			1:       ln = 16'hFFFF;
			2:       ln = 16'($urandom());
			default: ln = 16'($urandom_range(4000));
		endcase
		case ($urandom_range(7))
			0:       th = 12'd0;
			1:       th = 12'hFFF;
			default: th = 12'($urandom());
		endcase
		if ($urandom_range(3) == 0) begin
			write_reg($urandom_range(1) ? IDX_SPARE_LO : IDX_SPARE_HI, 17'($urandom()));
		end
		set_beam(live, ox, oy, ang, ln, th);
	endtask

	// mostly circles placed around the beam axis, past both ends and on both sides
	task automatic queue_random_circles(input int count);
		circle_t w;
		longint  sn, cs, t, off, reach;
		for (int n = 0; n < count; n++) begin
			w.r = ($urandom_range(4) == 0) ? RAD_W'($urandom()) : RAD_W'($urandom_range(600));
			if ($urandom_range(9) < 7) begin
				sn = sin_q15(angle);
				cs = sin_q15(ANG_W'(angle + 12'd1024));
				reach = longint'(thick) / 2 + longint'(w.r) + 32;
				t = longint'($urandom_range(32'(len) + 32'(len) / 4 + 64))
					- longint'(len) / 8 - 32;
				off = longint'($urandom_range(32'(2 * reach))) - reach;
				w.x = PT_W'(longint'(org_x) + (t * cs - off * sn) / 32768);
				w.y = PT_W'(longint'(org_y) + (t * sn + off * cs) / 32768);
			end else begin
				w.x = PT_W'($urandom());
				w.y = PT_W'($urandom());
			end
			circles_to_send.push_back(w);
		end
	endtask

	initial begin
		build_wave();
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// registers at reset: beam off
		offer_circle(0, 0, 4095);
		offer_circle(-65536, 65535, 0);
		wait_drained();

		// live only, so reset thickness and zero length apply
		write_reg(REG_BEAM_LIVE, 17'd1);
		settle();
		offer_circle(143, 0, 0);
		offer_circle(144, 0, 0);
		offer_circle(0, -144, 0);
		offer_circle(100, 100, 0);
		wait_drained();

		// along +x: behind start, alongside, past end, exact touches
		set_beam(1'b1, 17'd0, 17'd0, 12'd0, 16'd1600, 12'd288);
		offer_circle(0, 0, 0);
		offer_circle(-200, 0, 0);
		offer_circle(800, 143, 0);
		offer_circle(800, 144, 0);
		offer_circle(800, -144, 0);
		offer_circle(1743, 0, 0);
		offer_circle(1744, 0, 0);
		offer_circle(800, 400, 256);
		offer_circle(800, 399, 256);
		wait_drained();

		// corner origin pointing -y, longest and thickest beam
		set_beam(1'b1, 17'h10000, 17'h0FFFF, 12'd3072, 16'hFFFF, 12'hFFF);
		offer_circle(-65536, 35535, 4095);
		offer_circle(65535, -65536, 4095);
		offer_circle(-65536, 65535, 0);
		offer_circle(-65536, 0, 0);
		wait_drained();

		// zero thickness, zero length
		set_beam(1'b1, 17'h0FFFF, 17'h10000, 12'd4095, 16'd0, 12'd0);
		offer_circle(65535, -65536, 1);
		offer_circle(65535, -65536, 0);
		wait_drained();

		// oversized data keeps the low bits; spare indexes are ignored
		write_reg(REG_BEAM_LENGTH, 17'h10010);
		write_reg(REG_BEAM_ANGLE, 17'h1F400);
		write_reg(REG_BEAM_THICKNESS, 17'h1F000);
		write_reg(IDX_SPARE_LO, 17'h1FFFF);
		write_reg(IDX_SPARE_HI, 17'h1FFFF);
		write_reg(REG_BEAM_LIVE, 17'h1FFFE);
		settle();
		offer_circle(65535, -65536, 100);
		wait_drained();

		for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
			if (ph < RANDOM_PHASES / 3) begin
				tx_idle_pct = 20;
				rx_idle_pct = 82;
			end else if (ph < 2 * RANDOM_PHASES / 3) begin
				tx_idle_pct = 82;
				rx_idle_pct = 20;
			end else begin
				tx_idle_pct = 0;
				rx_idle_pct = 0;
			end
			load_random_beam();
			@(negedge clk);
			if (ph == RANDOM_PHASES - 3) begin
				rx_hold_left = LONG_HOLD;
			end
			queue_random_circles(WORDS_PER_PHASE);
			wait_drained();
		end

		repeat (4 * PIPE_LATENCY) @(posedge clk);
		bad_words += expected_hits.size();
		if (bad_words == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: filelist.f
+incdir+rtl
rtl/bchit_pkg.sv
rtl/bchit_cfg.sv
rtl/bchit_pipe.sv
rtl/beam_circle_hit_test_core.sv
rtl/bchit_checker.sv
tb/beam_circle_hit_test_core_test.sv
